[sv/ggapp_pkg.sv]
`default_nettype none

package ggapp_pkg;

   // Widths of the byte, the position counter and the accumulated fields.
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 7;
   localparam int DIGIT_W   = 4;
   localparam int LAT_DEG_W = 7;
   localparam int LON_DEG_W = 10;
   localparam int MIN_W     = 20;
   localparam int LAT_W     = 27;
   localparam int LON_W     = 31;

   // Ten-thousandths of a minute in one degree.
   localparam int MIN_PER_DEG = 600000;

   localparam logic [BYTE_W-1:0] CHAR_G     = 8'h47;
   localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4E;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // Character positions within the sentence, counted after the dropped byte.
   localparam logic [POS_W-1:0] POS_LAT_DEG_0 = 7'd11;
   localparam logic [POS_W-1:0] POS_LAT_DEG_1 = 7'd12;
   localparam logic [POS_W-1:0] POS_LAT_MIN_0 = 7'd13;
   localparam logic [POS_W-1:0] POS_LAT_MIN_1 = 7'd14;
   localparam logic [POS_W-1:0] POS_LAT_MIN_2 = 7'd16;
   localparam logic [POS_W-1:0] POS_LAT_MIN_3 = 7'd17;
   localparam logic [POS_W-1:0] POS_LAT_MIN_4 = 7'd18;
   localparam logic [POS_W-1:0] POS_LAT_MIN_5 = 7'd19;
   localparam logic [POS_W-1:0] POS_LAT_HEMI  = 7'd21;
   localparam logic [POS_W-1:0] POS_LON_DEG_0 = 7'd23;
   localparam logic [POS_W-1:0] POS_LON_DEG_1 = 7'd24;
   localparam logic [POS_W-1:0] POS_LON_DEG_2 = 7'd25;
   localparam logic [POS_W-1:0] POS_LON_MIN_0 = 7'd26;
   localparam logic [POS_W-1:0] POS_LON_MIN_1 = 7'd27;
   localparam logic [POS_W-1:0] POS_LON_MIN_2 = 7'd29;
   localparam logic [POS_W-1:0] POS_LON_MIN_3 = 7'd30;
   localparam logic [POS_W-1:0] POS_LON_MIN_4 = 7'd31;
   localparam logic [POS_W-1:0] POS_LON_MIN_5 = 7'd32;
   localparam logic [POS_W-1:0] POS_LON_HEMI  = 7'd34;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_SEEN_G,
      ST_SEEN_GG,
      ST_SKIP,
      ST_COLLECT
   } parse_state_type;

   // Fields of one finished sentence, handed from the parser to the result stage.
   typedef struct packed {
      logic [LAT_DEG_W-1:0] lat_deg;
      logic [MIN_W-1:0]     lat_min;
      logic                 lat_north;
      logic [LON_DEG_W-1:0] lon_deg;
      logic [MIN_W-1:0]     lon_min;
      logic                 lon_east;
      logic                 bad_digit;
   } fix_type;

endpackage

`default_nettype wire

[sv/ggapp_parser.sv]
`default_nettype none

module ggapp_parser import ggapp_pkg::*; #(
   parameter int MAX_POSITION = 100
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_in_byte,
   output logic                   fix_valid,
   input  wire logic              fix_ready,
   output fix_type                fix
);

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff;
   parse_state_type       state_ff, state_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [LAT_DEG_W-1:0]  lat_deg_ff, lat_deg_in;
   logic [MIN_W-1:0]      lat_min_ff, lat_min_in;
   logic                  lat_north_ff, lat_north_in;
   logic [LON_DEG_W-1:0]  lon_deg_ff, lon_deg_in;
   logic [MIN_W-1:0]      lon_min_ff, lon_min_in;
   logic                  lon_east_ff, lon_east_in;
   logic                  bad_ff, bad_in;

   logic                  accept;
   logic                  fire;
   logic                  is_star;
   logic                  is_g;
   logic                  is_digit;
   logic [DIGIT_W-1:0]    digit;

   assign is_star  = (in_byte_ff == CHAR_STAR);
   assign is_g     = (in_byte_ff == CHAR_G);
   assign is_digit = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign digit    = is_digit ? DIGIT_W'(in_byte_ff - CHAR_ZERO) : '0;

   // A star inside a sentence closes it and needs room in the result stage.
   assign fix_valid = in_valid_ff && is_star
                      && ((state_ff == ST_SKIP) || (state_ff == ST_COLLECT));
   assign fire      = in_valid_ff && (!fix_valid || fix_ready);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   assign fix.lat_deg   = lat_deg_ff;
   assign fix.lat_min   = lat_min_ff;
   assign fix.lat_north = lat_north_ff;
   assign fix.lon_deg   = lon_deg_ff;
   assign fix.lon_min   = lon_min_ff;
   assign fix.lon_east  = lon_east_ff;
   assign fix.bad_digit = bad_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      lat_deg_in   = lat_deg_ff;
      lat_min_in   = lat_min_ff;
      lat_north_in = lat_north_ff;
      lon_deg_in   = lon_deg_ff;
      lon_min_in   = lon_min_ff;
      lon_east_in  = lon_east_ff;
      bad_in       = bad_ff;
      if (fire) begin
         unique case (state_ff)
            ST_HUNT: begin
               state_in = is_g ? ST_SEEN_G : ST_HUNT;
            end
            ST_SEEN_G: begin
               state_in = is_g ? ST_SEEN_GG : ST_HUNT;
            end
            ST_SEEN_GG: begin
               if (in_byte_ff == CHAR_A) begin
                  state_in     = ST_SKIP;
                  pos_in       = '0;
                  lat_deg_in   = '0;
                  lat_min_in   = '0;
                  lat_north_in = 1'b0;
                  lon_deg_in   = '0;
                  lon_min_in   = '0;
                  lon_east_in  = 1'b0;
                  bad_in       = 1'b0;
               end else begin
                  // A further G keeps the last two as a possible start.
                  state_in = is_g ? ST_SEEN_GG : ST_HUNT;
               end
            end
            ST_SKIP: begin
               state_in = is_star ? ST_HUNT : ST_COLLECT;
            end
            ST_COLLECT: begin
               if (is_star) begin
                  state_in = ST_HUNT;
               end else begin
                  unique case (pos_ff)
                     POS_LAT_DEG_0, POS_LAT_DEG_1: begin
                        lat_deg_in = (lat_deg_ff << 3) + (lat_deg_ff << 1)
                                     + LAT_DEG_W'(digit);
                        bad_in     = bad_ff || !is_digit;
                     end
                     POS_LAT_MIN_0, POS_LAT_MIN_1, POS_LAT_MIN_2,
                     POS_LAT_MIN_3, POS_LAT_MIN_4, POS_LAT_MIN_5: begin
                        lat_min_in = (lat_min_ff << 3) + (lat_min_ff << 1)
                                     + MIN_W'(digit);
                        bad_in     = bad_ff || !is_digit;
                     end
                     POS_LAT_HEMI: begin
                        lat_north_in = (in_byte_ff == CHAR_N);
                     end
                     POS_LON_DEG_0, POS_LON_DEG_1, POS_LON_DEG_2: begin
                        lon_deg_in = (lon_deg_ff << 3) + (lon_deg_ff << 1)
                                     + LON_DEG_W'(digit);
                        bad_in     = bad_ff || !is_digit;
                     end
                     POS_LON_MIN_0, POS_LON_MIN_1, POS_LON_MIN_2,
                     POS_LON_MIN_3, POS_LON_MIN_4, POS_LON_MIN_5: begin
                        lon_min_in = (lon_min_ff << 3) + (lon_min_ff << 1)
                                     + MIN_W'(digit);
                        bad_in     = bad_ff || !is_digit;
                     end
                     POS_LON_HEMI: begin
                        lon_east_in = (in_byte_ff == CHAR_E);
                     end
                     default: begin
                     end
                  endcase
                  pos_in = (pos_ff < POS_W'(MAX_POSITION)) ? pos_ff + 1'b1
                                                           : POS_W'(MAX_POSITION);
               end
            end
            default: begin
               state_in = is_g ? ST_SEEN_G : ST_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ST_HUNT;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   // The sentence fields are cleared when a sentence starts, so they need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
      pos_ff       <= pos_in;
      lat_deg_ff   <= lat_deg_in;
      lat_min_ff   <= lat_min_in;
      lat_north_ff <= lat_north_in;
      lon_deg_ff   <= lon_deg_in;
      lon_min_ff   <= lon_min_in;
      lon_east_ff  <= lon_east_in;
      bad_ff       <= bad_in;
   end

endmodule

`default_nettype wire

[sv/ggapp_result.sv]
`default_nettype none

module ggapp_result import ggapp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fix_valid,
   output logic                         fix_ready,
   input  wire fix_type                 fix,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [LAT_W-1:0]      rsp_latitude,
   output logic signed [LON_W-1:0]      rsp_longitude,
   output logic                         rsp_format_error
);

   logic              mag_valid_ff, mag_valid_in;
   logic [LAT_W-1:0]  mag_lat_ff, mag_lat_in;
   logic [LON_W-1:0]  mag_lon_ff, mag_lon_in;
   logic              mag_north_ff;
   logic              mag_east_ff;
   logic              mag_err_ff;

   logic              out_valid_ff, out_valid_in;
   logic [LAT_W-1:0]  out_lat_ff, out_lat_in;
   logic [LON_W-1:0]  out_lon_ff, out_lon_in;
   logic              out_err_ff;

   logic              out_free;
   logic              move;
   logic              take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign move      = mag_valid_ff && out_free;
   assign fix_ready = !mag_valid_ff || move;
   assign take      = fix_valid && fix_ready;

   // First stage: magnitude in ten-thousandths of a minute.
   assign mag_lat_in = LAT_W'(fix.lat_deg) * LAT_W'(MIN_PER_DEG) + LAT_W'(fix.lat_min);
   assign mag_lon_in = LON_W'(fix.lon_deg) * LON_W'(MIN_PER_DEG) + LON_W'(fix.lon_min);

   // Second stage: apply the hemisphere. A zero magnitude stays zero.
   assign out_lat_in = mag_north_ff ? mag_lat_ff : LAT_W'(0) - mag_lat_ff;
   assign out_lon_in = mag_east_ff ? mag_lon_ff : LON_W'(0) - mag_lon_ff;

   assign mag_valid_in = take ? 1'b1 : (move ? 1'b0 : mag_valid_ff);
   assign out_valid_in = move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mag_valid_ff <= mag_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mag_lat_ff   <= mag_lat_in;
         mag_lon_ff   <= mag_lon_in;
         mag_north_ff <= fix.lat_north;
         mag_east_ff  <= fix.lon_east;
         mag_err_ff   <= fix.bad_digit;
      end
      if (move) begin
         out_lat_ff <= out_lat_in;
         out_lon_ff <= out_lon_in;
         out_err_ff <= mag_err_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_latitude     = $signed(out_lat_ff);
   assign rsp_longitude    = $signed(out_lon_ff);
   assign rsp_format_error = out_err_ff;

endmodule

`default_nettype wire

[sv/gga_position_parser_core.sv]
`default_nettype none

// GGA position parser. One received byte is taken per beat and the stream is
// searched for the sentence tag GGA. The byte after the tag is dropped, the
// latitude, longitude and hemisphere fields are collected from their fixed
// character positions, and the star that ends the sentence produces one result
// beat: signed latitude and longitude in ten-thousandths of a minute (negative
// for south and west) plus a flag that is set when a digit position held
// something other than a digit. The block takes a byte in every cycle unless
// the input stalls; a result passes from the input register through a two-stage
// result path (scaling, then sign) that can hold two finished results. The input
// stalls only when both of those stages are full and the output is stalled.
module gga_position_parser_core import ggapp_pkg::*; #(
   parameter int MAX_POSITION = 100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [BYTE_W-1:0]    req_in_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [LAT_W-1:0]   rsp_latitude,
   output logic signed [LON_W-1:0]   rsp_longitude,
   output logic                      rsp_format_error
);

   logic    fix_valid;
   logic    fix_ready;
   fix_type fix;

   ggapp_parser #(
      .MAX_POSITION (MAX_POSITION)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .fix_valid   (fix_valid),
      .fix_ready   (fix_ready),
      .fix         (fix)
   );

   ggapp_result u_result (
      .clock            (clock),
      .reset            (reset),
      .fix_valid        (fix_valid),
      .fix_ready        (fix_ready),
      .fix              (fix),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_latitude     (rsp_latitude),
      .rsp_longitude    (rsp_longitude),
      .rsp_format_error (rsp_format_error)
   );

endmodule

`default_nettype wire

[sv/ggapp_checker.sv]
`default_nettype none

module ggapp_checker import ggapp_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic signed [LAT_W-1:0] rsp_latitude,
   input wire logic signed [LON_W-1:0] rsp_longitude,
   input wire logic                 rsp_format_error
);

   localparam logic signed [LAT_W-1:0] LAT_LIMIT = 27'sd60399999;
   localparam logic signed [LON_W-1:0] LON_LIMIT = 31'sd600599999;

   // The input can only back up when the result path is full behind a stalled output.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the output was free");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_latitude) && $stable(rsp_longitude)
                                 && $stable(rsp_format_error))
      else $error("result payload changed while stalled");

   // Degrees and minutes hold at most their digit counts, which bounds the result.
   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |-> (rsp_latitude <= LAT_LIMIT) && (rsp_latitude >= -LAT_LIMIT)
                                  && (rsp_longitude <= LON_LIMIT)
                                  && (rsp_longitude >= -LON_LIMIT))
      else $error("result position out of range");

endmodule

bind gga_position_parser_core ggapp_checker u_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top import ggapp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAT_POSITION = 100;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_BEATS = 16;
   localparam int DRAIN_LIMIT  = 2000;

   typedef struct packed {
      logic [LAT_W-1:0] lat;
      logic [LON_W-1:0] lon;
      logic             err;
   } position_fix_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [LAT_W-1:0] rsp_latitude;
   logic signed [LON_W-1:0] rsp_longitude;
   logic                rsp_format_error;

   // Parser state as seen from the byte stream.
   parse_state_type     hunt_stage = ST_HUNT;
   logic                in_sentence = 1'b0;
   logic                drop_next = 1'b0;
   logic [POS_W-1:0]    char_pos = '0;
   logic [LAT_DEG_W-1:0] lat_deg_acc = '0;
   logic [MIN_W-1:0]    lat_min_acc = '0;
   logic                north = 1'b0;
   logic [LON_DEG_W-1:0] lon_deg_acc = '0;
   logic [MIN_W-1:0]    lon_min_acc = '0;
   logic                east = 1'b0;
   logic                digit_fault = 1'b0;

   position_fix_type    pending_fixes[$];
   position_fix_type    due_fix;

   int                  src_idle_pct = 13;
   int                  sink_idle_pct = 45;
   int                  error_count = 0;
   int                  fixes_checked = 0;
   int                  bytes_accepted = 0;
   int                  cycle_count = 0;

   gga_position_parser_core #(
      .MAX_POSITION(SAT_POSITION)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_latitude     (rsp_latitude),
      .rsp_longitude    (rsp_longitude),
      .rsp_format_error (rsp_format_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("gga_position_parser_core regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < sink_idle_pct);
      end
   end

   // Signed position in ten-thousandths of a minute; a zero magnitude stays zero.
   function automatic logic [63:0] signed_minutes(input longint deg, input longint min,
                                                  input logic positive);
      longint v;
      v = deg * MIN_PER_DEG + min;
      if (!positive) v = -v;
      return v;
   endfunction

   task automatic follow_byte(input logic [BYTE_W-1:0] b);
      logic             is_digit;
      logic [3:0]       dv;
      logic [63:0]      lat_v;
      logic [63:0]      lon_v;
      position_fix_type fix;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      dv = is_digit ? b[3:0] : 4'd0;
      if (!in_sentence) begin
         case (hunt_stage)
            ST_SEEN_G: begin
               hunt_stage = (b == CHAR_G) ? ST_SEEN_GG : ST_HUNT;
            end
            ST_SEEN_GG: begin
               if (b == CHAR_A) begin
                  hunt_stage = ST_HUNT;
                  in_sentence = 1'b1;
                  drop_next = 1'b1;
                  char_pos = '0;
                  lat_deg_acc = '0;
                  lat_min_acc = '0;
                  north = 1'b0;
                  lon_deg_acc = '0;
                  lon_min_acc = '0;
                  east = 1'b0;
                  digit_fault = 1'b0;
               end else begin
                  // A further G keeps the two latest G characters in play.
                  hunt_stage = (b == CHAR_G) ? ST_SEEN_GG : ST_HUNT;
               end
            end
            default: begin
               hunt_stage = (b == CHAR_G) ? ST_SEEN_G : ST_HUNT;
            end
         endcase
      end else if (b == CHAR_STAR) begin
         lat_v = signed_minutes(lat_deg_acc, lat_min_acc, north);
         lon_v = signed_minutes(lon_deg_acc, lon_min_acc, east);
         fix.lat = lat_v[LAT_W-1:0];
         fix.lon = lon_v[LON_W-1:0];
         fix.err = digit_fault;
         pending_fixes.push_back(fix);
         in_sentence = 1'b0;
         drop_next = 1'b0;
         hunt_stage = ST_HUNT;
      end else if (drop_next) begin
         drop_next = 1'b0;
      end else begin
         case (char_pos)
            POS_LAT_DEG_0, POS_LAT_DEG_1: begin
               lat_deg_acc = LAT_DEG_W'(lat_deg_acc * 10 + dv);
               digit_fault |= !is_digit;
            end
            POS_LAT_MIN_0, POS_LAT_MIN_1, POS_LAT_MIN_2,
            POS_LAT_MIN_3, POS_LAT_MIN_4, POS_LAT_MIN_5: begin
               lat_min_acc = MIN_W'(lat_min_acc * 10 + dv);
               digit_fault |= !is_digit;
            end
            POS_LAT_HEMI: begin
               north = (b == CHAR_N);
            end
            POS_LON_DEG_0, POS_LON_DEG_1, POS_LON_DEG_2: begin
               lon_deg_acc = LON_DEG_W'(lon_deg_acc * 10 + dv);
               digit_fault |= !is_digit;
            end
            POS_LON_MIN_0, POS_LON_MIN_1, POS_LON_MIN_2,
            POS_LON_MIN_3, POS_LON_MIN_4, POS_LON_MIN_5: begin
               lon_min_acc = MIN_W'(lon_min_acc * 10 + dv);
               digit_fault |= !is_digit;
            end
            POS_LON_HEMI: begin
               east = (b == CHAR_E);
            end
            default: ;
         endcase
         if (char_pos < SAT_POSITION) char_pos++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fixes.size() == 0) begin
            $display("%0t ns: unexpected fix, expected none, got lat %0d lon %0d err %0b",
                     $time, rsp_latitude, rsp_longitude, rsp_format_error);
            error_count++;
         end else begin
            due_fix = pending_fixes.pop_front();
            fixes_checked++;
            if (rsp_latitude !== due_fix.lat) begin
               $display("%0t ns: latitude expected %0d, got %0d",
                        $time, $signed(due_fix.lat), rsp_latitude);
               error_count++;
            end
            if (rsp_longitude !== due_fix.lon) begin
               $display("%0t ns: longitude expected %0d, got %0d",
                        $time, $signed(due_fix.lon), rsp_longitude);
               error_count++;
            end
            if (rsp_format_error !== due_fix.err) begin
               $display("%0t ns: format_error expected %0b, got %0b",
                        $time, due_fix.err, rsp_format_error);
               error_count++;
            end
         end
      end
   end

   // Every call starts and ends just after a rising edge; valid is lowered only for a gap.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      follow_byte(b);
      bytes_accepted++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Everything after the tag: the dropped comma, time, latitude and longitude, no star.
   function automatic string gga_body(input int lat_deg, input int lat_min, input byte ns,
                                      input int lon_deg, input int lon_min, input byte ew,
                                      input string tail);
      return $sformatf(",%06d.%03d,%02d%02d.%04d,%c,%03d%02d.%04d,%c%s",
                       $urandom_range(235959), $urandom_range(999),
                       lat_deg, lat_min / 10000, lat_min % 10000, ns,
                       lon_deg, lon_min / 10000, lon_min % 10000, ew, tail);
   endfunction

   function automatic string random_tail(input int n);
      string alphabet;
      string tail;
      int    k;
      alphabet = "0123456789.,MGANE$-";
      tail = "";
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(alphabet.len() - 1);
         tail = {tail, alphabet.substr(k, k)};
      end
      return tail;
   endfunction

   function automatic int pick_value(input int top);
      case ($urandom_range(7))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(top);
      endcase
   endfunction

   function automatic byte pick_letter(input byte yes, input byte no);
      int r;
      r = $urandom_range(9);
      if (r < 4) return yes;
      if (r < 8) return no;
      return byte'($urandom_range(33, 126));
   endfunction

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0:       send_byte(CHAR_G);
            1:       send_byte(CHAR_A);
            2:       send_byte(CHAR_STAR);
            default: send_byte(BYTE_W'($urandom_range(255)));
         endcase
      end
   endtask

   task automatic test_tag_hunt();
      // Stars and partial tags while hunting must not produce a fix.
      send_text("*GA*GG*");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hC7);
      send_text({"$GPGGA", gga_body(48, 70380, CHAR_N, 11, 310000, CHAR_E, ",1,08,0.9"), "*"});
      send_text({"GGGGA", gga_body(33, 512345, "S", 151, 123456, "W", ""), "*"});
      send_text({"GAGGA", gga_body(1, 1, CHAR_N, 1, 1, "W", ",M,,"), "*"});
   endtask

   task automatic test_field_extremes();
      send_text({"GGA", gga_body(99, 999999, CHAR_N, 999, 999999, CHAR_E, ""), "*"});
      send_text({"GGA", gga_body(99, 999999, "S", 999, 999999, "W", ""), "*"});
      // Zero magnitude in the southern and western hemispheres stays zero.
      send_text({"GGA", gga_body(0, 0, "S", 0, 0, "W", ""), "*"});
      send_text({"GGA", gga_body(12, 345678, "n", 123, 456789, "e", ""), "*"});
   endtask

   task automatic test_malformed_fields();
      string s;
      s = gga_body(45, 123456, CHAR_N, 90, 654321, CHAR_E, "");
      s[12] = ":";
      s[31] = "/";
      send_text({"GGA", s, "*"});
      // A byte with the top bit set and a null byte at digit positions.
      s = gga_body(45, 123456, "S", 90, 654321, "W", ",1");
      send_text({"GGA", s.substr(0, 11)});
      send_byte(8'h00);
      send_text(s.substr(13, 17));
      send_byte(8'hFF);
      send_text({s.substr(19, s.len() - 1), "*"});
      // A star in the dropped byte ends the sentence with cleared fields.
      send_text("GGA*");
   endtask

   task automatic test_sentence_length();
      string s;
      send_text("GGA,123*");
      send_text("GGA,123519.000,4807.0*");
      send_text("GGA,123519.000,4807.0381,N,0113*");
      // Past the last field the position saturates; a tag in the tail is ignored.
      s = gga_body(7, 77777, CHAR_N, 77, 777777, CHAR_E, random_tail(90));
      send_text({"GGA", s, "GGA,00*"});
   endtask

   task automatic test_random_traffic(input int src_pct, input int sink_pct, input int budget);
      int    sent;
      int    pick;
      int    k;
      string s;
      string prefix;
      src_idle_pct = src_pct;
      sink_idle_pct = sink_pct;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_noise($urandom_range(1, 20));
         end else begin
            case ($urandom_range(3))
               0:       prefix = "$GP";
               1:       prefix = "$GN";
               2:       prefix = "GG";
               default: prefix = "";
            endcase
            s = gga_body(pick_value(99), pick_value(999999), pick_letter(CHAR_N, "S"),
                         pick_value(999), pick_value(999999), pick_letter(CHAR_E, "W"),
                         random_tail(($urandom_range(9) == 0) ? $urandom_range(70, 90)
                                                                : $urandom_range(30)));
            if (pick < 25) begin
               for (int m = $urandom_range(1, 3); m > 0; m--) begin
                  k = $urandom_range(s.len() - 1);
                  s[k] = byte'($urandom_range(1, 255));
               end
            end else if (pick < 30) begin
               s = s.substr(0, $urandom_range(s.len() - 1));
            end
            s = {prefix, "GGA", s, "*"};
            send_text(s);
            sent += s.len();
         end
      end
   endtask

   task automatic wait_for_drain();
      int waited;
      waited = 0;
      while (pending_fixes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_fixes.size() != 0) begin
         $display("%0t ns: %0d fixes never arrived", $time, pending_fixes.size());
         error_count++;
      end
      repeat (SETTLE_BEATS) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tag_hunt();
      test_field_extremes();
      test_malformed_fields();
      test_sentence_length();
      test_random_traffic(13, 45, 400);
      test_random_traffic(45, 13, 400);
      test_random_traffic(0, 0, 400);
      req_valid <= 1'b0;
      wait_for_drain();
      $display("Checked %0d position fixes over %0d accepted beats of serial text.",
               fixes_checked, bytes_accepted);
      $display("Covered tag overlaps, field extremes, bad digits, short and long sentences.");
      if (error_count == 0) begin
         $display("gga_position_parser_core regression: pass");
      end else begin
         $display("gga_position_parser_core regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
